// File: rtl/core/arwi_pkg.sv
// Package for the auto-radix word-to-integer unit: widths, character codes,
// controller state type and the character classification functions.
// No dependencies.
package arwi_pkg;

  // Field widths of the input and result beats
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 6;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 7;

  // Default depth of the digit store
  localparam int MAX_DIGITS_DEF = 64;

  // Character codes used by the decoder
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'd90;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LZ    = 8'd122;

  // Letters map to digit 10 and up
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_LOAD = 3'b100
  } arwi_state_t;

  // Decoded character
  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               bad;
  } arwi_digit_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
  endfunction

  // Map 0-9, A-Z, a-z to 0..35; anything else is digit 0 and flagged bad
  function automatic arwi_digit_t digit_of(input logic [CHAR_W-1:0] c);
    arwi_digit_t r;
    logic [CHAR_W-1:0] t;
    r.bad = 1'b0;
    t     = '0;
    if ((c >= CHAR_0) && (c <= CHAR_9)) begin
      t = c - CHAR_0;
    end else if ((c >= CHAR_UA) && (c <= CHAR_Z)) begin
      t = c - CHAR_UA + LETTER_OFS;
    end else if ((c >= CHAR_LA) && (c <= CHAR_LZ)) begin
      t = c - CHAR_LA + LETTER_OFS;
    end else begin
      r.bad = 1'b1;
    end
    r.digit = t[DIGIT_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/core/arwi_if.sv
// Valid/ready channel interfaces of the auto-radix word-to-integer unit:
// one for character beats, one for result beats.
// Depends on arwi_pkg.
interface arwi_in_if;
  logic                          valid;
  logic                          ready;
  logic [arwi_pkg::CHAR_W-1:0]   char_code;
  logic                          end_of_stream;

  modport source (output valid, char_code, end_of_stream, input ready);
  modport sink   (input valid, char_code, end_of_stream, output ready);
endinterface

interface arwi_out_if;
  logic                          valid;
  logic                          ready;
  logic [arwi_pkg::DIGIT_W-1:0]  base;
  logic [arwi_pkg::VALUE_W-1:0]  value;
  logic [arwi_pkg::COUNT_W-1:0]  digit_count;
  logic                          overflow;
  logic                          bad_char;

  modport source (output valid, base, value, digit_count, overflow, bad_char, input ready);
  modport sink   (input valid, base, value, digit_count, overflow, bad_char, output ready);
endinterface

// File: rtl/core/auto_radix_word_to_integer_unit.sv
// Top level of the auto-radix word-to-integer unit: digit store memory,
// word tracking and the Horner evaluation sequencer.
// Depends on arwi_pkg and the channel interfaces in arwi_if.sv.
//
// Usage: the in_ch channel takes one character per beat. Whitespace (codes
// 9 to 13 and 32) or a beat with end_of_stream set closes an open word; other
// characters are stored as base-36 digits, lowercase folded to uppercase,
// anything else stored as digit 0 with bad_char raised.
// The out_ch channel delivers one beat per closed word: base (largest digit
// plus one), value modulo 2^64, digit_count, overflow and bad_char.
// Throughput: one character beat per cycle while idle. A closing beat starts
// a walk of the stored digits through the digit memory, one read and one
// 64x6 multiply-add per cycle; in_ch.ready is low during the walk.
// The result waits in an output register; characters of the next word are
// taken while it waits, and only the next walk's result load waits on it.
// Reset (rst_n low, synchronous) closes any open word and empties the output
// register. The digit memory is not cleared; entries are only read after
// they are written in the current word.
module auto_radix_word_to_integer_unit #(
  parameter int MAX_DIGITS = arwi_pkg::MAX_DIGITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  arwi_in_if.sink    in_ch,
  arwi_out_if.source out_ch
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int DW = arwi_pkg::DIGIT_W;
  localparam int VW = arwi_pkg::VALUE_W;
  localparam int NW = arwi_pkg::COUNT_W;
  localparam int MW = VW + DW;

  // Controller and word state
  arwi_pkg::arwi_state_t state_r, state_nxt;
  logic          in_word_r, in_word_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] largest_r, largest_nxt;
  logic          bad_r, bad_nxt;
  logic          drop_r, drop_nxt;

  // Evaluation state
  logic [CW-1:0] idx_r, idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [DW-1:0] rd_data_r;
  logic [VW-1:0] acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;

  // Result register
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_base_r;
  logic [VW-1:0] out_value_r;
  logic [NW-1:0] out_count_r;
  logic          out_ovf_r;
  logic          out_bad_r;

  // Digit store
  logic [DW-1:0] mem [MAX_DIGITS];

  logic                 accept;
  logic                 closing;
  arwi_pkg::arwi_digit_t dec;
  logic [CW-1:0]        cnt_eff;
  logic [DW-1:0]        largest_eff;
  logic                 bad_eff;
  logic                 drop_eff;
  logic                 has_room;
  logic                 wr_en;
  logic                 rd_en;
  logic [DW-1:0]        base_w;
  logic [MW-1:0]        mac;
  logic                 eval_done;
  logic                 load;
  logic [CW+NW-1:0]     cnt_ext;

  assign in_ch.ready = (state_r == arwi_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign closing     = in_ch.end_of_stream || arwi_pkg::is_blank(in_ch.char_code);
  assign dec         = arwi_pkg::digit_of(in_ch.char_code);

  // A new word starts from cleared tracking state
  assign cnt_eff     = in_word_r ? cnt_r : '0;
  assign largest_eff = in_word_r ? largest_r : '0;
  assign bad_eff     = in_word_r && bad_r;
  assign drop_eff    = in_word_r && drop_r;
  assign has_room    = (cnt_eff < CW'(MAX_DIGITS));
  assign wr_en       = accept && !closing && has_room;

  // Horner step: one read beat folded into the accumulator per cycle
  assign rd_en     = (state_r == arwi_pkg::ST_EVAL) && (idx_r != cnt_r);
  assign base_w    = largest_r + DW'(1);
  assign mac       = MW'(acc_r) * MW'(base_w) + MW'(rd_data_r);
  assign eval_done = (idx_r == cnt_r) && !rd_vld_r;
  assign load      = (state_r == arwi_pkg::ST_LOAD) && (!out_valid_r || out_ch.ready);
  assign cnt_ext   = {{NW{1'b0}}, cnt_r};

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    in_word_nxt   = in_word_r;
    cnt_nxt       = cnt_r;
    largest_nxt   = largest_r;
    bad_nxt       = bad_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    rd_vld_nxt    = 1'b0;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      arwi_pkg::ST_IDLE: begin
        if (accept) begin
          if (closing) begin
            // Close the word and start the walk
            if (in_word_r) begin
              state_nxt = arwi_pkg::ST_EVAL;
              idx_nxt   = '0;
              acc_nxt   = '0;
              ovf_nxt   = 1'b0;
            end
          end else begin
            in_word_nxt = 1'b1;
            cnt_nxt     = cnt_eff;
            largest_nxt = largest_eff;
            bad_nxt     = bad_eff || dec.bad;
            drop_nxt    = drop_eff;
            if (has_room) begin
              cnt_nxt = cnt_eff + CW'(1);
              if (dec.digit > largest_eff) begin
                largest_nxt = dec.digit;
              end
            end else begin
              drop_nxt = 1'b1;
            end
          end
        end
      end
      arwi_pkg::ST_EVAL: begin
        // Issue reads, fold returned digits
        if (rd_en) begin
          idx_nxt    = idx_r + CW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          acc_nxt = mac[VW-1:0];
          ovf_nxt = ovf_r || (|mac[MW-1:VW]);
        end
        if (eval_done) begin
          state_nxt = arwi_pkg::ST_LOAD;
        end
      end
      arwi_pkg::ST_LOAD: begin
        // Hold until the result register is free
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = arwi_pkg::ST_IDLE;
          in_word_nxt   = 1'b0;
          cnt_nxt       = '0;
          largest_nxt   = '0;
          bad_nxt       = 1'b0;
          drop_nxt      = 1'b0;
        end
      end
      default: begin
        state_nxt = arwi_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arwi_pkg::ST_IDLE;
      in_word_r   <= 1'b0;
      cnt_r       <= '0;
      largest_r   <= '0;
      bad_r       <= 1'b0;
      drop_r      <= 1'b0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_word_r   <= in_word_nxt;
      cnt_r       <= cnt_nxt;
      largest_r   <= largest_nxt;
      bad_r       <= bad_nxt;
      drop_r      <= drop_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Accumulator and result payload
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (load) begin
      out_base_r  <= base_w;
      out_value_r <= acc_r;
      out_count_r <= cnt_ext[NW-1:0];
      out_ovf_r   <= ovf_r || drop_r;
      out_bad_r   <= bad_r;
    end
  end

  // Digit store: write on a stored character, registered read during the walk.
  // Input is held off during the walk, so reads and writes never overlap.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_eff[AW-1:0]] <= dec.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.base        = out_base_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.digit_count = out_count_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.bad_char    = out_bad_r;

`ifndef NO_ASSERTIONS
  // Stored digit count never exceeds the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  // A walk only runs over a non-empty open word and never passes its count
  a_eval_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == arwi_pkg::ST_EVAL) |-> (in_word_r && (cnt_r != '0) && (idx_r <= cnt_r)))
    else $error("walk without a valid word");

  // A read beat returns only while walking
  a_rd_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == arwi_pkg::ST_EVAL))
    else $error("read data outside the walk");

  // A new result appears only from the load state
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == arwi_pkg::ST_LOAD))
    else $error("result raised without a load");

  // Reported base lies in 1..36
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_base_r != '0) && (out_base_r <= DW'(36))))
    else $error("base out of range");
`endif

endmodule

// File: verif/auto_radix_word_to_integer_unit_tb.sv
// Testbench for auto_radix_word_to_integer_unit: character beats in, one
// result beat per closed word out, checked against an in-bench word predictor.
// Depends on arwi_pkg and the channel interfaces of arwi_if.sv.
import arwi_pkg::*;

typedef struct packed {
  logic [DIGIT_W-1:0] base;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] digit_count;
  logic               overflow;
  logic               bad_char;
} word_result_t;

// Track the open word, predict each word result and compare arrivals in order
class word_scoreboard;
  localparam int DEPTH = MAX_DIGITS_DEF;

  logic [DIGIT_W-1:0] digit_mem [DEPTH];
  int unsigned        stored;
  logic [DIGIT_W-1:0] top_digit;
  bit                 open_word;
  bit                 saw_bad;
  bit                 saw_drop;
  word_result_t       expected_words [$];
  int unsigned        mismatches;

  function new();
    stored     = 0;
    top_digit  = '0;
    open_word  = 1'b0;
    saw_bad    = 1'b0;
    saw_drop   = 1'b0;
    mismatches = 0;
  endfunction

  static function bit is_space(input logic [CHAR_W-1:0] c);
    return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPACE);
  endfunction

  // Evaluate the stored digits most significant first, modulo 2^64
  function word_result_t close_word();
    word_result_t      r;
    logic [VALUE_W-1:0] acc;
    logic [127:0]      wide;
    bit                ovf;
    acc = '0;
    ovf = 1'b0;
    r.base = top_digit + 1'b1;
    for (int i = 0; i < stored; i++) begin
      wide = 128'(acc) * 128'(r.base) + 128'(digit_mem[i]);
      if (wide[127:64] != '0) ovf = 1'b1;
      acc = wide[63:0];
    end
    r.value       = acc;
    r.digit_count = stored[COUNT_W-1:0];
    r.overflow    = ovf || saw_drop;
    r.bad_char    = saw_bad;
    open_word = 1'b0;
    stored    = 0;
    top_digit = '0;
    saw_bad   = 1'b0;
    saw_drop  = 1'b0;
    return r;
  endfunction

  // Apply one accepted character beat to the word state
  function void note_beat(input logic [CHAR_W-1:0] c, input logic eos);
    logic [CHAR_W-1:0]  t;
    logic [DIGIT_W-1:0] d;
    bit                 bad;
    if (eos || is_space(c)) begin
      if (open_word) expected_words.push_back(close_word());
      return;
    end
    if (!open_word) begin
      open_word = 1'b1;
      stored    = 0;
      top_digit = '0;
      saw_bad   = 1'b0;
      saw_drop  = 1'b0;
    end
    bad = 1'b0;
    t   = '0;
    if (c >= CHAR_0 && c <= CHAR_9) t = c - CHAR_0;
    else if (c >= CHAR_UA && c <= CHAR_Z) t = c - CHAR_UA + LETTER_OFS;
    else if (c >= CHAR_LA && c <= CHAR_LZ) t = c - CHAR_LA + LETTER_OFS;
    else bad = 1'b1;
    d = t[DIGIT_W-1:0];
    // Drop digits once the store is full
    if (stored < DEPTH) begin
      digit_mem[stored] = d;
      stored++;
      if (d > top_digit) top_digit = d;
    end else begin
      saw_drop = 1'b1;
    end
    if (bad) saw_bad = 1'b1;
  endfunction

  function void check_word(input word_result_t got);
    word_result_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result beat: base=%0d value=%h count=%0d ovf=%b bad=%b",
                 got.base, got.value, got.digit_count, got.overflow, got.bad_char);
      return;
    end
    want = expected_words.pop_front();
    if (got.base !== want.base || got.value !== want.value ||
        got.digit_count !== want.digit_count || got.overflow !== want.overflow ||
        got.bad_char !== want.bad_char) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: want base=%0d value=%h count=%0d ovf=%b bad=%b",
                 want.base, want.value, want.digit_count, want.overflow, want.bad_char);
        $display("                 got  base=%0d value=%h count=%0d ovf=%b bad=%b",
                 got.base, got.value, got.digit_count, got.overflow, got.bad_char);
      end
    end
  endfunction

  function int pending();
    return expected_words.size();
  endfunction

  function bit failed();
    return (mismatches != 0) || (expected_words.size() != 0);
  endfunction
endclass

module auto_radix_word_to_integer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = MAX_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = DEPTH + 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  arwi_in_if  in_if ();
  arwi_out_if out_if ();

  auto_radix_word_to_integer_unit #(
    .MAX_DIGITS(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  word_scoreboard sb;
  int             burst_left;
  int             word_items;
  int             long_hold;
  int             cycles;

  always #5 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one character beat, opening a gap between bursts
  task automatic offer_beat(input logic [CHAR_W-1:0] c, input logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_if.valid         <= 1'b0;
      in_if.char_code     <= 8'($urandom_range(0, 255));
      in_if.end_of_stream <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.char_code     <= c;
    in_if.end_of_stream <= eos;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    sb.note_beat(c, eos);
    @(negedge clk);
  endtask

  // Hold the sender until every predicted word has come back
  task automatic drain_words();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Send one word with random content, then a blank or end of stream
  task automatic send_random_word();
    int                len;
    int                lim;
    int                d;
    int                pick;
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] blanks [6];
    blanks = '{CHAR_TAB, 8'd10, 8'd11, 8'd12, CHAR_CR, CHAR_SPACE};
    // Occasional noise: blanks or end of stream with no word open
    pick = $urandom_range(0, 19);
    if (pick == 0) offer_beat(8'($urandom_range(0, 255)), 1'b1);
    else if (pick < 3) repeat ($urandom_range(1, 3)) offer_beat(blanks[$urandom_range(0, 5)], 1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 80) len = $urandom_range(1, 16);
    else if (pick < 95) len = $urandom_range(17, 40);
    else len = $urandom_range(DEPTH - 4, DEPTH + 8);
    lim = $urandom_range(1, 36);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 6) begin
        // Any byte that is neither blank nor alphanumeric
        do begin
          c = 8'($urandom_range(0, 255));
        end while (arwi_pkg::is_blank(c) || (c >= CHAR_0 && c <= CHAR_9) ||
                   (c >= CHAR_UA && c <= CHAR_Z) || (c >= CHAR_LA && c <= CHAR_LZ));
      end else begin
        d = $urandom_range(0, lim - 1);
        if (d < 10) c = CHAR_0 + 8'(d);
        else if ($urandom_range(0, 1) == 1) c = CHAR_UA + 8'(d) - LETTER_OFS;
        else c = CHAR_LA + 8'(d) - LETTER_OFS;
      end
      offer_beat(c, 1'b0);
    end
    if ($urandom_range(0, 9) == 0) offer_beat(8'($urandom_range(0, 255)), 1'b1);
    else offer_beat(blanks[$urandom_range(0, 5)], 1'b0);
    word_items += len + 1;
  endtask

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    word_result_t got;
    int           rx_mode;
    int           rx_left;
    int           phase;
    logic         rdy;
    out_if.ready = 1'b0;
    rx_mode      = 0;
    rx_left      = 0;
    phase        = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        rdy = 1'b0;
        long_hold--;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        phase++;
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((phase % 3) != 2);
        endcase
      end
      out_if.ready <= rdy;
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
        got.base        = out_if.base;
        got.value       = out_if.value;
        got.digit_count = out_if.digit_count;
        got.overflow    = out_if.overflow;
        got.bad_char    = out_if.bad_char;
        sb.check_word(got);
      end
    end
  end

  // Sender: reset, directed beats, random words, drain
  initial begin
    logic [CHAR_W:0] directed_beats [27];
    bit              hold_done;
    bit              pause_done;
    sb                  = new();
    cycles              = 0;
    burst_left          = 0;
    word_items          = 0;
    long_hold           = 0;
    hold_done           = 1'b0;
    pause_done          = 1'b0;
    in_if.valid         = 1'b0;
    in_if.char_code     = '0;
    in_if.end_of_stream = 1'b0;
    // {end_of_stream, char_code}
    directed_beats = '{
      {1'b0, CHAR_SPACE},                       // blank outside a word
      {1'b1, CHAR_UA},                          // end of stream with no word
      {1'b0, CHAR_0}, {1'b0, CHAR_SPACE},       // base 1 word
      {1'b0, CHAR_9}, {1'b0, CHAR_LZ}, {1'b0, CHAR_Z}, {1'b0, CHAR_LA},
      {1'b0, CHAR_TAB},
      {1'b0, CHAR_UA}, {1'b0, 8'd10},
      // bytes just outside each accepted range
      {1'b0, 8'd8}, {1'b0, 8'd14}, {1'b0, 8'd47}, {1'b0, 8'd58}, {1'b0, 8'd64},
      {1'b0, 8'd91}, {1'b0, 8'd96}, {1'b0, 8'd123}, {1'b0, 8'd11},
      {1'b0, 8'hFF}, {1'b0, 8'd12},
      {1'b0, 8'h00}, {1'b0, 8'h80}, {1'b1, 8'h00}, // closed by end of stream
      {1'b0, CHAR_9 - 8'd8}, {1'b0, CHAR_CR}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_beats[i])
      offer_beat(directed_beats[i][CHAR_W-1:0], directed_beats[i][CHAR_W]);
    drain_words();

    while (word_items < RANDOM_ITEMS) begin
      // Hold the receiver off while words keep coming, to back up the input
      if (!hold_done && word_items >= 250) begin
        long_hold = 400;
        hold_done = 1'b1;
      end
      if (!pause_done && word_items >= 500) begin
        drain_words();
        pause_done = 1'b1;
      end
      send_random_word();
    end

    drain_words();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failed()) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule
